/* hdl/tach_rpm_meter_core_macros.svh */
// assertion helpers for the tachometer rate meter checks
`ifndef TACH_RPM_METER_CORE_MACROS_SVH
`define TACH_RPM_METER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TACH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tach_rpm_meter_core: implication check failed");

// next-cycle implication, checked on every rising edge outside reset
`define TACH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tach_rpm_meter_core: next-cycle check failed");

`endif

/* hdl/tach_pkg.sv */
package tach_pkg;

  localparam int HISTORY_DEPTH = 10;

  localparam int COUNT_W   = 17;
  localparam int TIMEOUT_W = 16;
  localparam int TPM_W     = 24;
  localparam int MINP_W    = 4;
  localparam int RATE_W    = 16;

  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int PULSE_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W   = COUNT_W + $clog2(HISTORY_DEPTH);
  localparam int NUM_W   = PULSE_W + TPM_W;
  localparam int CMP_W   = SUM_W + RATE_W;
  localparam int DIV_CNT_W = $clog2(RATE_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TPM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MINUTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSES       = 2'd2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [TPM_W-1:0]     TPM_RESET     = 24'd60000;
  localparam logic [MINP_W-1:0]    MINP_RESET    = 4'd5;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic tach_main;
    logic tach_second;
  } tach_in_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_main;
    logic [RATE_W-1:0] rate_second;
  } tach_out_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [TPM_W-1:0]     ticks_per_minute;
    logic [MINP_W-1:0]    min_pulses;
  } tach_cfg_t;

endpackage

/* hdl/tach_ram.sv */
module tach_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/tach_lane.sv */
module tach_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            level,
  input  tach_pkg::tach_cfg_t             cfg,
  output logic                            busy,
  output logic [tach_pkg::RATE_W-1:0]     rate
);
  import tach_pkg::*;

  typedef enum logic [2:0] {L_IDLE, L_UPD, L_MUL, L_CHK, L_DIV} lane_state_t;

  lane_state_t state;

  logic                     last_level;
  logic [COUNT_W-1:0]       elapsed;
  logic [SLOT_W-1:0]        slot;
  logic [HISTORY_DEPTH-1:0] slot_valid;
  logic [SUM_W-1:0]         sum;
  logic [PULSE_W-1:0]       pulses;
  logic                     store;
  logic [COUNT_W-1:0]       new_val;
  logic [NUM_W-1:0]         num;
  logic [SUM_W-1:0]         rem;
  logic [RATE_W-1:0]        quot;
  logic [DIV_CNT_W-1:0]     div_cnt;

  logic [COUNT_W-1:0] cnt_inc;
  logic               timed_out;
  logic               falling;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] old_val;
  logic [SUM_W-1:0]   sum_next;
  logic [PULSE_W-1:0] pulses_next;
  logic [SLOT_W-1:0]  slot_next;
  logic [SUM_W:0]     trial;
  logic               fits;
  logic [RATE_W-1:0]  quot_next;
  logic               ram_we;

  tach_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot),
    .wr_data (new_val),
    .rd_en   (start),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  always_comb begin
    cnt_inc   = elapsed + COUNT_W'(1);
    timed_out = cnt_inc > COUNT_W'(cfg.timeout_ticks);
    falling   = last_level && !level;

    // entries never written read as an empty period
    old_val     = slot_valid[slot] ? rd_data : '0;
    sum_next    = sum - SUM_W'(old_val) + SUM_W'(new_val);
    pulses_next = pulses - PULSE_W'(old_val != '0) + PULSE_W'(new_val != '0);
    slot_next   = (slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
    ram_we      = (state == L_UPD) && store;

    // one restoring divide step, remainder always stays below sum
    trial     = {rem, quot[RATE_W-1]};
    fits      = trial >= {1'b0, sum};
    quot_next = {quot[RATE_W-2:0], fits};
  end

  assign busy = (state != L_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= L_IDLE;
      last_level <= 1'b0;
      elapsed    <= '0;
      slot       <= '0;
      slot_valid <= '0;
      sum        <= '0;
      pulses     <= '0;
      rate       <= '0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            store      <= falling || timed_out;
            new_val    <= timed_out ? '0 : cnt_inc;
            elapsed    <= (falling || timed_out) ? '0 : cnt_inc;
            last_level <= level;
            state      <= L_UPD;
          end
        end
        L_UPD: begin
          if (store) begin
            slot_valid[slot] <= 1'b1;
            sum              <= sum_next;
            pulses           <= pulses_next;
            slot             <= slot_next;
          end
          state <= L_MUL;
        end
        L_MUL: begin
          num   <= NUM_W'(pulses) * NUM_W'(cfg.ticks_per_minute);
          state <= L_CHK;
        end
        L_CHK: begin
          if ((PULSE_W + MINP_W)'(pulses) < (PULSE_W + MINP_W)'(cfg.min_pulses)
              || sum == '0) begin
            rate  <= '0;
            state <= L_IDLE;
          end else if (CMP_W'(num) >= {sum, {RATE_W{1'b0}}}) begin
            rate  <= RATE_MAX;
            state <= L_IDLE;
          end else begin
            rem     <= SUM_W'(num >> RATE_W);
            quot    <= num[RATE_W-1:0];
            div_cnt <= '0;
            state   <= L_DIV;
          end
        end
        L_DIV: begin
          rem     <= fits ? SUM_W'(trial - {1'b0, sum}) : SUM_W'(trial);
          quot    <= quot_next;
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(RATE_W - 1)) begin
            rate  <= quot_next;
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tach_rpm_meter_core.sv */
// Two-channel fan tachometer rate meter. Each accepted request is one sampling
// tick carrying both tachometer levels and yields one result with both rates
// in pulses per minute. The period ring slot is read at the accepting edge.
// After that come the update of the ring and its running sum and pulse count,
// one multiply, one range check and a 16-step restoring divider. Then the core
// sees both lanes idle and loads the output register. Both channels work side
// by side. When neither channel needs the divider (rate 0 or saturated) the
// divider steps are skipped. The next request is taken the cycle after the
// result is loaded, even while that result still waits to be taken. A result
// that finds the previous one still waiting is held until that one is taken.
// Config writes take effect at once and belong in idle periods. Rates read 0
// until min_pulses nonzero periods are held and saturate at 65535.
module tach_rpm_meter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tach_pkg::tach_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tach_pkg::tach_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [tach_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tach_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tach_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} core_state_t;

  core_state_t state;
  tach_cfg_t   cfg;

  logic              start;
  logic              busy_main;
  logic              busy_second;
  logic [RATE_W-1:0] rate_main;
  logic [RATE_W-1:0] rate_second;

  assign in_stall = (state != S_IDLE);
  assign start    = in_valid && !in_stall;

  tach_lane u_lane_main (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .level (in_data.tach_main),
    .cfg   (cfg),
    .busy  (busy_main),
    .rate  (rate_main)
  );

  tach_lane u_lane_second (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .level (in_data.tach_second),
    .cfg   (cfg),
    .busy  (busy_second),
    .rate  (rate_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks    <= TIMEOUT_RESET;
      cfg.ticks_per_minute <= TPM_RESET;
      cfg.min_pulses       <= MINP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT_TICKS:    cfg.timeout_ticks    <= cfg_data[TIMEOUT_W-1:0];
        CFG_TICKS_PER_MINUTE: cfg.ticks_per_minute <= cfg_data[TPM_W-1:0];
        CFG_MIN_PULSES:       cfg.min_pulses       <= cfg_data[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in S_DONE the load below decides out_valid
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!busy_main && !busy_second) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.rate_main   <= rate_main;
            out_data.rate_second <= rate_second;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tach_rpm_meter_core_chk.sv */
`include "tach_rpm_meter_core_macros.svh"

module tach_rpm_meter_core_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tach_pkg::tach_out_t out_data
);

  // an accepted request keeps the block busy, with in_stall high, after it is taken
  `TACH_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall ##1 in_stall)

  // a held result does not change
  `TACH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // a new result only appears after a request was being worked on
  `TACH_ASSERT_IMP(a_out_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind tach_rpm_meter_core tach_rpm_meter_core_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
